FILE: design/bounded_stack_with_search_macros.svh
// Assertion macros for the bounded stack with search.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef BOUNDED_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

// cond must imply prop in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// cond must imply prop in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

// cond must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: design/bsws_pkg.sv
// Shared types and constants for the bounded stack with search.
// No dependencies; used by bsws_ram, bsws_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bsws_pkg;

	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int CMD_W  = 3;
	localparam int CAP_W  = 7;
	localparam int POS_W  = 6;
	localparam int FILL_W = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_FIND  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} ram_wr_t;

endpackage

`default_nettype wire

FILE: design/bounded_stack_with_search.sv
// Bounded LIFO stack with top-down search, top level.
// From accept, push, clear and unused codes pass through the execute and response states; pop
// and peek add a state for one registered store read; find adds one compare per entry from
// the top down (none when empty). One request at a time; the next is taken the cycle after
// the result is registered, and a result still held in the output register stalls the response.
// Reset (arst_n low, asynchronous): fill count 0, capacity 64, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_with_search (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    cmd,
	input  logic [31:0]                   operand_word,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [31:0]                   data_out,
	output logic [5:0]                    found_position,
	output logic [6:0]                    fill_count,
	// capacity register write
	input  logic                          cfg_we,
	input  logic [6:0]                    cfg_wdata
);

	// store write request and read address from the sequencer
	bsws_pkg::ram_wr_t                 wr;
	logic [bsws_pkg::ADDR_W-1:0]       rd_addr;
	logic [bsws_pkg::WORD_W-1:0]       rd_data;

	// Sequencer: holds the fill count and capacity, decodes each request, and
	// for find walks the store from the top entry down, one compare per cycle,
	// stopping at the first match. The result sits in an output register so a
	// new request is taken while the previous result still waits.
	bsws_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.operand_word   (operand_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.data_out       (data_out),
		.found_position (found_position),
		.fill_count     (fill_count),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.wr             (wr),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data)
	);

	// Entry store: no reset; only entries below the fill count are ever used,
	// and every one of those was written by a push.
	bsws_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

FILE: design/bsws_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on bsws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsws_ram (
	input  logic                      clk,
	input  bsws_pkg::ram_wr_t         wr,
	input  logic [bsws_pkg::ADDR_W-1:0] rd_addr,
	output logic [bsws_pkg::WORD_W-1:0] rd_data
);

	logic [bsws_pkg::WORD_W-1:0] mem [bsws_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: design/bsws_ctrl.sv
// Command sequencer: decodes requests, drives the entry store and runs the
// top-down search one entry per cycle through a single comparator.
// Depends on bsws_pkg and bounded_stack_with_search_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_stack_with_search_macros.svh"

module bsws_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bsws_pkg::CMD_W-1:0]    cmd,
	input  logic [bsws_pkg::WORD_W-1:0]   operand_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bsws_pkg::WORD_W-1:0]   data_out,
	output logic [bsws_pkg::POS_W-1:0]    found_position,
	output logic [bsws_pkg::FILL_W-1:0]   fill_count,
	input  logic                          cfg_we,
	input  logic [bsws_pkg::CAP_W-1:0]    cfg_wdata,
	output bsws_pkg::ram_wr_t             wr,
	output logic [bsws_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [bsws_pkg::WORD_W-1:0]   rd_data
);

	localparam int CntW  = bsws_pkg::CNT_W;
	localparam int AddrW = bsws_pkg::ADDR_W;
	localparam int WordW = bsws_pkg::WORD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCAN,
		S_RESP
	} state_t;

	state_t                       state_q;
	logic [bsws_pkg::CMD_W-1:0]   cmd_q;
	logic [WordW-1:0]             key_q;
	logic [CntW-1:0]              count_q;
	logic [bsws_pkg::CAP_W-1:0]   cap_q;
	logic [AddrW-1:0]             idx_q;

	bsws_pkg::status_t            res_status_q;
	logic [WordW-1:0]             res_data_q;
	logic [AddrW-1:0]             res_pos_q;

	logic                         out_valid_q;
	bsws_pkg::status_t            status_q;
	logic [WordW-1:0]             data_out_q;
	logic [AddrW-1:0]             pos_out_q;
	logic [CntW-1:0]              fill_q;

	logic                         full;
	logic                         empty;
	logic [CntW-1:0]              top_w;
	logic [AddrW-1:0]             top_addr;
	logic                         hit;

	// capacity is the smaller of the register and the store depth
	assign full     = (count_q >= CntW'(cap_q)) || (count_q >= CntW'(bsws_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign top_w    = count_q - CntW'(1);
	assign top_addr = top_w[AddrW-1:0];
	assign hit      = (rd_data == key_q);

	always_comb begin
		wr      = '0;
		rd_addr = (state_q == S_SCAN) ? (idx_q - AddrW'(1)) : top_addr;
		if (state_q == S_EXEC && cmd_q == bsws_pkg::CMD_PUSH && !full) begin
			wr.en   = 1'b1;
			wr.addr = count_q[AddrW-1:0];
			wr.data = key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= bsws_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// load a new result when the output register is free, else drop a taken one
			if (state_q == S_RESP) begin
				if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						key_q   <= operand_word;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_status_q <= bsws_pkg::ST_OK;
					res_data_q   <= '0;
					res_pos_q    <= '0;
					state_q      <= S_RESP;
					unique case (cmd_q)
						bsws_pkg::CMD_PUSH: begin
							if (full) begin
								res_status_q <= bsws_pkg::ST_FULL;
							end else begin
								count_q <= count_q + CntW'(1);
							end
						end
						bsws_pkg::CMD_POP, bsws_pkg::CMD_PEEK: begin
							if (empty) begin
								res_status_q <= bsws_pkg::ST_EMPTY;
							end else begin
								state_q <= S_READ;
							end
						end
						bsws_pkg::CMD_CLEAR: begin
							count_q <= '0;
						end
						bsws_pkg::CMD_FIND: begin
							if (empty) begin
								res_status_q <= bsws_pkg::ST_NOTFOUND;
							end else begin
								idx_q   <= top_addr;
								state_q <= S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
				S_READ: begin
					res_data_q <= rd_data;
					if (cmd_q == bsws_pkg::CMD_POP) begin
						count_q <= top_w;
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (hit) begin
						res_pos_q <= idx_q;
						state_q   <= S_RESP;
					end else if (idx_q == '0) begin
						res_status_q <= bsws_pkg::ST_NOTFOUND;
						state_q      <= S_RESP;
					end else begin
						idx_q <= idx_q - AddrW'(1);
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						status_q    <= res_status_q;
						data_out_q  <= res_data_q;
						pos_out_q   <= res_pos_q;
						fill_q      <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign data_out       = data_out_q;
	assign found_position = bsws_pkg::POS_W'(pos_out_q);
	assign fill_count     = bsws_pkg::FILL_W'(fill_q);

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CntW'(bsws_pkg::DEPTH), "count above depth")
	`ASSERT_NEXT(a_accept_exec, clk, arst_n, in_valid && in_ready, state_q == S_EXEC, "accept lost")
	`ASSERT_NEXT(a_push_grows, clk, arst_n, wr.en, count_q == $past(count_q) + CntW'(1), "push count")
	`ASSERT_IMPLIES(a_scan_range, clk, arst_n, state_q == S_SCAN, CntW'(idx_q) < count_q, "scan index")

endmodule

`default_nettype wire
